// File: sv/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

  localparam int unsigned AddrW = 5;

  localparam logic [2:0] RegStartFrame  = 3'd0;
  localparam logic [2:0] RegEndFrame    = 3'd1;
  localparam logic [2:0] RegStartRow    = 3'd2;
  localparam logic [2:0] RegEndRow      = 3'd3;
  localparam logic [2:0] RegFramePeriod = 3'd4;
  localparam logic [2:0] RegPlayMode    = 3'd5;
  localparam logic [2:0] RegCellWidth   = 3'd6;
  localparam logic [2:0] RegCellHeight  = 3'd7;

  localparam logic [2:0] ModeLoopFwd = 3'd0;
  localparam logic [2:0] ModeLoopBwd = 3'd1;
  localparam logic [2:0] ModeOnceFwd = 3'd2;
  localparam logic [2:0] ModeOnceBwd = 3'd3;

  localparam logic OpTick    = 1'b0;
  localparam logic OpRestart = 1'b1;

  localparam logic [2:0]  RstStartFrame  = 3'd0;
  localparam logic [2:0]  RstEndFrame    = 3'd7;
  localparam logic [7:0]  RstStartRow    = 8'd0;
  localparam logic [7:0]  RstEndRow      = 8'd0;
  localparam logic [23:0] RstFramePeriod = 24'd100000;
  localparam logic [2:0]  RstPlayMode    = ModeLoopFwd;
  localparam logic [10:0] RstCellWidth   = 11'd256;
  localparam logic [10:0] RstCellHeight  = 11'd256;

  typedef struct packed {
    logic [2:0]  start_frame;
    logic [2:0]  end_frame;
    logic [7:0]  start_row;
    logic [7:0]  end_row;
    logic [23:0] frame_period;
    logic [2:0]  play_mode;
    logic [10:0] cell_width;
    logic [10:0] cell_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  row;
    logic [31:0] acc;
    logic        done;
    logic        holding;
  } seq_state_t;

endpackage

`default_nettype wire

// File: sv/sprite_frame_sequencer.sv
// Sprite-sheet animation stepper.
// Input channel (in_valid_i / in_stall_o) carries one word per item: op_i selects a
// tick, which adds elapsed_us_i to the time accumulator and steps at most one frame
// when a period has elapsed, or a restart, which reloads the start position.
// Output channel (out_valid_o / out_stall_i) returns one word per item: the new
// frame column and row, their pixel offsets and the sticky done flag.
// An accepted word passes from the input register to the result register, which
// sets out_valid_o; one item is taken every cycle while the receiver does not stall,
// through the combinational accumulate, compare and step between the two registers.
// When the receiver stalls, the result word holds and the input register still
// takes one more word; after that in_stall_o rises until the result is taken.
// Reset empties both registers, clears position, accumulator and done flag, and
// loads the default configuration. Configuration, set through APB, acts on the next
// tick and at once on the pixel offsets; write it only while no word is in flight.
`default_nettype none

module sprite_frame_sequencer #(
  parameter int unsigned FramesPerRow = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      op_i,
  input  wire logic [15:0]               elapsed_us_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic      [12:0]               cell_left_o,
  output logic      [17:0]               cell_top_o,
  output logic      [2:0]                frame_col_o,
  output logic      [7:0]                frame_row_o,
  output logic                           done_res_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [sfs_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);

  localparam int unsigned ColW = ($clog2(FramesPerRow) > 3) ? $clog2(FramesPerRow) : 3;

  sfs_pkg::cfg_t       cfg;
  sfs_pkg::seq_state_t st_q, st_d;
  logic [ColW-1:0]     col_q, col_d;

  logic        in_valid_q;
  logic        op_q;
  logic [15:0] el_q;
  logic        in_load;
  logic        adv;

  logic            out_valid_q;
  logic [ColW-1:0] res_col_q;
  logic [7:0]      res_row_q;
  logic            res_done_q;

  logic [ColW+10:0] left_prod;
  logic [18:0]      top_prod;

  sfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfs_step #(
    .FramesPerRow (FramesPerRow),
    .ColW         (ColW)
  ) u_step (
    .cfg_i        (cfg),
    .col_i        (col_q),
    .st_i         (st_q),
    .op_i         (op_q),
    .elapsed_us_i (el_q),
    .col_o        (col_d),
    .st_o         (st_d)
  );

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !(!out_valid_q || !out_stall_i);
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      op_q <= op_i;
      el_q <= elapsed_us_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      st_q  <= '0;
    end else if (adv) begin
      col_q <= col_d;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_col_q  <= col_d;
      res_row_q  <= st_d.row;
      res_done_q <= st_d.done;
    end
  end

  assign left_prod = {11'd0, res_col_q} * {{ColW{1'b0}}, cfg.cell_width};
  assign top_prod  = {11'd0, res_row_q} * {8'd0, cfg.cell_height};

  assign out_valid_o = out_valid_q;
  assign cell_left_o = left_prod[12:0];
  assign cell_top_o  = top_prod[17:0];
  assign frame_col_o = res_col_q[2:0];
  assign frame_row_o = res_row_q;
  assign done_res_o  = res_done_q;

  a_hold_implies_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.holding |-> st_q.done)
    else $error("holding set without done");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  a_adv_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced word did not reach the result register");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && op_q == sfs_pkg::OpRestart) |=> (st_q.acc == '0 && !st_q.done && !st_q.holding))
    else $error("restart did not clear the sequence state");

endmodule

`default_nettype wire

// File: sv/sfs_regs.sv
`default_nettype none

module sfs_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sfs_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output sfs_pkg::cfg_t                   cfg_o
);

  sfs_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_frame  <= sfs_pkg::RstStartFrame;
      cfg_q.end_frame    <= sfs_pkg::RstEndFrame;
      cfg_q.start_row    <= sfs_pkg::RstStartRow;
      cfg_q.end_row      <= sfs_pkg::RstEndRow;
      cfg_q.frame_period <= sfs_pkg::RstFramePeriod;
      cfg_q.play_mode    <= sfs_pkg::RstPlayMode;
      cfg_q.cell_width   <= sfs_pkg::RstCellWidth;
      cfg_q.cell_height  <= sfs_pkg::RstCellHeight;
    end else if (wr_en) begin
      unique case (idx)
        sfs_pkg::RegStartFrame:  cfg_q.start_frame  <= pwdata[2:0];
        sfs_pkg::RegEndFrame:    cfg_q.end_frame    <= pwdata[2:0];
        sfs_pkg::RegStartRow:    cfg_q.start_row    <= pwdata[7:0];
        sfs_pkg::RegEndRow:      cfg_q.end_row      <= pwdata[7:0];
        sfs_pkg::RegFramePeriod: cfg_q.frame_period <= pwdata[23:0];
        sfs_pkg::RegPlayMode:    cfg_q.play_mode    <= pwdata[2:0];
        sfs_pkg::RegCellWidth:   cfg_q.cell_width   <= pwdata[10:0];
        sfs_pkg::RegCellHeight:  cfg_q.cell_height  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sfs_pkg::RegStartFrame:  prdata = {29'd0, cfg_q.start_frame};
      sfs_pkg::RegEndFrame:    prdata = {29'd0, cfg_q.end_frame};
      sfs_pkg::RegStartRow:    prdata = {24'd0, cfg_q.start_row};
      sfs_pkg::RegEndRow:      prdata = {24'd0, cfg_q.end_row};
      sfs_pkg::RegFramePeriod: prdata = {8'd0, cfg_q.frame_period};
      sfs_pkg::RegPlayMode:    prdata = {29'd0, cfg_q.play_mode};
      sfs_pkg::RegCellWidth:   prdata = {21'd0, cfg_q.cell_width};
      sfs_pkg::RegCellHeight:  prdata = {21'd0, cfg_q.cell_height};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/sfs_step.sv
`default_nettype none

module sfs_step #(
  parameter int unsigned FramesPerRow = 8,
  parameter int unsigned ColW         = 3
) (
  input  wire sfs_pkg::cfg_t       cfg_i,
  input  wire logic [ColW-1:0]     col_i,
  input  wire sfs_pkg::seq_state_t st_i,
  input  wire logic                op_i,
  input  wire logic [15:0]         elapsed_us_i,
  output logic      [ColW-1:0]     col_o,
  output sfs_pkg::seq_state_t      st_o
);

  localparam logic [ColW:0]   Fpr     = FramesPerRow[ColW:0];
  localparam logic [ColW-1:0] LastCol = ColW'(FramesPerRow - 1);

  logic [32:0]   sum;
  logic [31:0]   acc_sat;
  logic          due;
  logic [ColW:0] col_inc;
  logic [ColW:0] end_ext;
  logic [ColW:0] start_ext;
  logic [ColW:0] col_ext;
  logic          loop_fwd;

  assign sum       = {1'b0, st_i.acc} + {17'd0, elapsed_us_i};
  assign acc_sat   = sum[32] ? '1 : sum[31:0];
  assign due       = !st_i.holding && (cfg_i.play_mode <= sfs_pkg::ModeOnceBwd)
                     && (acc_sat >= {8'd0, cfg_i.frame_period});
  assign col_ext   = {1'b0, col_i};
  assign col_inc   = col_ext + 1'b1;
  assign end_ext   = (ColW + 1)'(cfg_i.end_frame);
  assign start_ext = (ColW + 1)'(cfg_i.start_frame);
  assign loop_fwd  = (cfg_i.play_mode == sfs_pkg::ModeLoopFwd);

  always_comb begin
    col_o = col_i;
    st_o  = st_i;
    if (op_i == sfs_pkg::OpRestart) begin
      col_o        = ColW'(cfg_i.start_frame);
      st_o.row     = cfg_i.start_row;
      st_o.acc     = '0;
      st_o.done    = 1'b0;
      st_o.holding = 1'b0;
    end else begin
      st_o.acc = acc_sat;
      if (due) begin
        st_o.acc = acc_sat - {8'd0, cfg_i.frame_period};
        case (cfg_i.play_mode) inside
          sfs_pkg::ModeLoopFwd, sfs_pkg::ModeOnceFwd: begin
            if (st_i.row == cfg_i.end_row && col_inc > end_ext) begin
              st_o.done = 1'b1;
              if (loop_fwd) begin
                col_o    = ColW'(cfg_i.start_frame);
                st_o.row = cfg_i.start_row;
              end else begin
                col_o        = ColW'(cfg_i.end_frame);
                st_o.row     = cfg_i.end_row;
                st_o.holding = 1'b1;
              end
            end else if (col_inc >= Fpr) begin
              st_o.row = st_i.row + 8'd1;
              col_o    = '0;
            end else begin
              col_o = col_inc[ColW-1:0];
            end
          end
          sfs_pkg::ModeLoopBwd: begin
            if (st_i.row == cfg_i.start_row && col_ext <= start_ext) begin
              st_o.done = 1'b1;
              col_o     = ColW'(cfg_i.end_frame);
              st_o.row  = cfg_i.end_row;
            end else if (col_i == '0) begin
              st_o.row = st_i.row - 8'd1;
              col_o    = LastCol;
            end else begin
              col_o = col_i - 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire
